// ----- rtl/ccbv_pkg.sv -----
// Shared types, constants and helper functions for the cubical cell birth value block.
// Has no dependencies. Every other file in rtl takes it in by wildcard import.
package ccbv_pkg;

  // Default geometry and value width of the voxel store.
  localparam int SIDE_DEF       = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths of the request and result ports.
  localparam int CORD_W = 9;
  localparam int CELL_W = 29;
  localparam int VAL_W  = 32;
  localparam int EXT_W  = 5;
  localparam int DIM_W  = 2;

  // Configuration port widths.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_EXTENT_X  = 3'd0;
  localparam logic [2:0] REG_EXTENT_Y  = 3'd1;
  localparam logic [2:0] REG_EXTENT_Z  = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_SENTINEL  = 3'd4;

  // Register reset values.
  localparam logic [EXT_W-1:0] EXTENT_RST    = 5'd31;
  localparam logic [VAL_W-1:0] THRESHOLD_RST = 32'h7FFF_FFFF;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Cell dimensions.
  localparam logic [DIM_W-1:0] DIM_VERTEX = 2'd0;
  localparam logic [DIM_W-1:0] DIM_EDGE   = 2'd1;
  localparam logic [DIM_W-1:0] DIM_SQUARE = 2'd2;
  localparam logic [DIM_W-1:0] DIM_CUBE   = 2'd3;

  // Cell orientations.
  localparam logic [1:0] ORIENT_X    = 2'd0;
  localparam logic [1:0] ORIENT_Y    = 2'd1;
  localparam logic [1:0] ORIENT_Z    = 2'd2;
  localparam logic [1:0] ORIENT_NONE = 2'd3;

  // A written -1.0 in Q16.16 is replaced by the threshold in sentinel mode.
  localparam logic [VAL_W-1:0] SENTINEL_Q16 = 32'hFFFF_0000;

  // Configuration register contents.
  typedef struct packed {
    logic [EXT_W-1:0] extent_x;
    logic [EXT_W-1:0] extent_y;
    logic [EXT_W-1:0] extent_z;
    logic [VAL_W-1:0] threshold;
    logic             sentinel;
  } cfg_t;

  // Tag that travels with each corner read to the reduction stage.
  typedef struct packed {
    logic valid;      // a corner read was issued last cycle
    logic pad;        // the corner lies in the padding border
    logic first;      // first corner of the query
    logic last;       // last corner of the query
    logic force_thr;  // the query answers with the threshold
  } rd_tag_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WAIT
  } seq_state_t;

  // Stored word width: never narrower than a full threshold value.
  function automatic int word_bits(input int value_bits);
    return (value_bits > VAL_W) ? value_bits : VAL_W;
  endfunction

  // Corners of a cell as a mask; bit k holds offsets x=k[0], y=k[1], z=k[2].
  function automatic logic [7:0] corner_mask(input logic [DIM_W-1:0] dim,
                                             input logic [1:0] orient);
    logic [7:0] m;
    m = 8'h01;
    unique case (dim)
      DIM_VERTEX: m = 8'h01;
      DIM_EDGE: begin
        unique case (orient)
          ORIENT_X: m = 8'h03;
          ORIENT_Y: m = 8'h05;
          ORIENT_Z: m = 8'h11;
          default:  m = 8'h01;
        endcase
      end
      DIM_SQUARE: begin
        unique case (orient)
          ORIENT_X: m = 8'h0F;
          ORIENT_Y: m = 8'h33;
          ORIENT_Z: m = 8'h55;
          default:  m = 8'h01;
        endcase
      end
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // Edges and squares with no valid orientation answer with the threshold.
  function automatic logic force_threshold(input logic [DIM_W-1:0] dim,
                                           input logic [1:0] orient);
    return ((dim == DIM_EDGE) || (dim == DIM_SQUARE)) && (orient == ORIENT_NONE);
  endfunction

endpackage

// ----- rtl/ccbv_cfg.sv -----
// Configuration register file behind the APB-style port.
// Depends on ccbv_pkg for register indexes, reset values and cfg_t.
module ccbv_cfg
  import ccbv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_AW-1:2];

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extent_x  <= EXTENT_RST;
      cfg.extent_y  <= EXTENT_RST;
      cfg.extent_z  <= EXTENT_RST;
      cfg.threshold <= THRESHOLD_RST;
      cfg.sentinel  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EXTENT_X:  cfg.extent_x  <= pwdata[EXT_W-1:0];
        REG_EXTENT_Y:  cfg.extent_y  <= pwdata[EXT_W-1:0];
        REG_EXTENT_Z:  cfg.extent_z  <= pwdata[EXT_W-1:0];
        REG_THRESHOLD: cfg.threshold <= pwdata[VAL_W-1:0];
        REG_SENTINEL:  cfg.sentinel  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_EXTENT_X:  prdata = APB_DW'(cfg.extent_x);
      REG_EXTENT_Y:  prdata = APB_DW'(cfg.extent_y);
      REG_EXTENT_Z:  prdata = APB_DW'(cfg.extent_z);
      REG_THRESHOLD: prdata = APB_DW'(cfg.threshold);
      REG_SENTINEL:  prdata = APB_DW'(cfg.sentinel);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/ccbv_store.sv -----
// Voxel store: one synchronous memory, one write and one read port, registered read data.
// Depends on ccbv_pkg for the word width helper.
module ccbv_store
  import ccbv_pkg::*;
#(
  parameter int SIDE       = SIDE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [$clog2(SIDE*SIDE*SIDE)-1:0]     waddr,
  input  logic [word_bits(VALUE_BITS)-1:0]      wdata,
  input  logic                                  re,
  input  logic [$clog2(SIDE*SIDE*SIDE)-1:0]     raddr,
  output logic [word_bits(VALUE_BITS)-1:0]      rdata
);

  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int WB    = word_bits(VALUE_BITS);

  logic [WB-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ccbv_seq.sv -----
// Request sequencer: performs voxel writes and walks the corners of a queried cell,
// one memory read per cycle. Depends on ccbv_pkg for codes, cfg_t, rd_tag_t and the FSM type.
module ccbv_seq
  import ccbv_pkg::*;
#(
  parameter int SIDE       = SIDE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfg_t                                  cfg,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation,
  input  logic [CORD_W-1:0]                     voxel_x,
  input  logic [CORD_W-1:0]                     voxel_y,
  input  logic [CORD_W-1:0]                     voxel_z,
  input  logic [VAL_W-1:0]                      voxel_value,
  input  logic [CELL_W-1:0]                     cell_index,
  input  logic [DIM_W-1:0]                      cell_dim,
  output logic                                  we,
  output logic [$clog2(SIDE*SIDE*SIDE)-1:0]     waddr,
  output logic [word_bits(VALUE_BITS)-1:0]      wdata,
  output logic                                  re,
  output logic [$clog2(SIDE*SIDE*SIDE)-1:0]     raddr,
  output rd_tag_t                               tag
);

  localparam int WB      = word_bits(VALUE_BITS);
  localparam int NB      = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int CW      = $clog2(SIDE);
  localparam int AW      = $clog2(SIDE * SIDE * SIDE);
  localparam int SIDE_SQ = SIDE * SIDE;
  localparam logic [CORD_W:0] SIDE_C = (CORD_W + 1)'(SIDE);

  seq_state_t        state, state_next;
  logic              accept;
  logic [CORD_W-1:0] base_x, base_y, base_z;
  logic [7:0]        mask, mask_rest;
  logic              first, force_thr;
  logic [2:0]        sel;
  logic [CORD_W:0]   cx, cy, cz;
  logic              corner_in;
  rd_tag_t           tag_next;
  logic signed [NB-1:0] value_narrow;

  // One axis lies in the interior when it is 1..extent and inside the store.
  function automatic logic in_axis(input logic [CORD_W:0] c, input logic [EXT_W-1:0] ext);
    return (c != '0) && (c <= (CORD_W + 1)'(ext)) && (c < SIDE_C);
  endfunction

  function automatic logic [AW-1:0] voxel_addr(input logic [CORD_W:0] x,
                                               input logic [CORD_W:0] y,
                                               input logic [CORD_W:0] z);
    return AW'(x[CW-1:0]) + AW'(y[CW-1:0]) * AW'(SIDE) + AW'(z[CW-1:0]) * AW'(SIDE_SQ);
  endfunction

  // Lowest pending corner.
  function automatic logic [2:0] lowest(input logic [7:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (m[k]) idx = 3'(k);
    end
    return idx;
  endfunction

  assign accept = start && !busy;

  // Write path: a write takes effect at the edge that accepts it.
  assign value_narrow = voxel_value[NB-1:0];
  always_comb begin
    we    = accept && (operation == OP_WRITE) &&
            in_axis({1'b0, voxel_x}, cfg.extent_x) &&
            in_axis({1'b0, voxel_y}, cfg.extent_y) &&
            in_axis({1'b0, voxel_z}, cfg.extent_z);
    waddr = voxel_addr({1'b0, voxel_x}, {1'b0, voxel_y}, {1'b0, voxel_z});
    if (cfg.sentinel && (voxel_value == SENTINEL_Q16)) begin
      wdata = WB'($signed(cfg.threshold));
    end else begin
      wdata = WB'(value_narrow);
    end
  end

  // Corner selection and read address.
  always_comb begin
    sel       = lowest(mask);
    mask_rest = mask & ~(8'b1 << sel);
    cx        = {1'b0, base_x} + (CORD_W + 1)'(sel[0]);
    cy        = {1'b0, base_y} + (CORD_W + 1)'(sel[1]);
    cz        = {1'b0, base_z} + (CORD_W + 1)'(sel[2]);
    corner_in = in_axis(cx, cfg.extent_x) && in_axis(cy, cfg.extent_y) &&
                in_axis(cz, cfg.extent_z);
    raddr     = voxel_addr(cx, cy, cz);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && (operation == OP_QUERY)) state_next = S_READ;
      S_READ: if (mask_rest == 8'h00) state_next = S_WAIT;
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy               = (state != S_IDLE);
    re                 = (state == S_READ);
    tag_next.valid     = (state == S_READ);
    tag_next.pad       = !corner_in;
    tag_next.first     = first;
    tag_next.last      = (mask_rest == 8'h00);
    tag_next.force_thr = force_thr;
  end

  // Control registers and the tag that goes with each read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tag   <= '0;
    end else begin
      state <= state_next;
      tag   <= tag_next;
    end
  end

  // Query context.
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_QUERY)) begin
      base_x    <= cell_index[CORD_W-1:0];
      base_y    <= cell_index[2*CORD_W-1:CORD_W];
      base_z    <= cell_index[3*CORD_W-1:2*CORD_W];
      mask      <= corner_mask(cell_dim, cell_index[CELL_W-1:3*CORD_W]);
      force_thr <= force_threshold(cell_dim, cell_index[CELL_W-1:3*CORD_W]);
      first     <= 1'b1;
    end else if (state == S_READ) begin
      mask  <= mask_rest;
      first <= 1'b0;
    end
  end

endmodule

// ----- rtl/ccbv_acc.sv -----
// Max reduction over the corner values of one query and the result register.
// Depends on ccbv_pkg for rd_tag_t and the word width helper.
module ccbv_acc
  import ccbv_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [VAL_W-1:0]                 threshold,
  input  rd_tag_t                          tag,
  input  logic [word_bits(VALUE_BITS)-1:0] rdata,
  output logic                             done,
  output logic [VAL_W-1:0]                 birth_value
);

  localparam int WB = word_bits(VALUE_BITS);

  logic signed [WB-1:0] value, acc, merged;

  // Padding corners read as the threshold; keep the running maximum.
  always_comb begin
    value = tag.pad ? WB'($signed(threshold)) : $signed(rdata);
    if (tag.first || (value > acc)) begin
      merged = value;
    end else begin
      merged = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag.valid && tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      acc <= merged;
    end
    if (tag.valid && tag.last) begin
      birth_value <= tag.force_thr ? threshold : merged[VAL_W-1:0];
    end
  end

endmodule

// ----- rtl/cubical_cell_birth_value_core.sv -----
// Top level of the cubical cell birth value block: configuration, sequencer, voxel store
// and max reduction. Depends on ccbv_pkg, ccbv_cfg, ccbv_seq, ccbv_store and ccbv_acc.
//
// A request is taken at the clock edge where start is high and busy is low. A voxel write
// is done at that edge and leaves busy low, so requests can follow every cycle. A query
// reads its cell's 1, 2, 4 or 8 corners (1 for an edge or square with orientation 3)
// from the voxel memory's read port one per cycle. It holds busy through its read and
// wait states, and its result shows on birth_value with done high for one cycle once the
// last read has passed the read data register and the result register. The next request
// can be taken in the cycle the result shows. The receiver cannot stall: done is a
// one-cycle strobe. The memory needs no clearing after reset; reading a voxel never
// written returns an undefined value.
module cubical_cell_birth_value_core
  import ccbv_pkg::*;
#(
  parameter int SIDE       = SIDE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [CORD_W-1:0] voxel_x,
  input  logic [CORD_W-1:0] voxel_y,
  input  logic [CORD_W-1:0] voxel_z,
  input  logic [VAL_W-1:0]  voxel_value,
  input  logic [CELL_W-1:0] cell_index,
  input  logic [DIM_W-1:0]  cell_dim,
  output logic              done,
  output logic [VAL_W-1:0]  birth_value
);

  localparam int WB = word_bits(VALUE_BITS);
  localparam int AW = $clog2(SIDE * SIDE * SIDE);

  cfg_t          cfg;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [WB-1:0] wdata, rdata;
  rd_tag_t       tag;

  ccbv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccbv_seq #(
    .SIDE       (SIDE),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .voxel_x     (voxel_x),
    .voxel_y     (voxel_y),
    .voxel_z     (voxel_z),
    .voxel_value (voxel_value),
    .cell_index  (cell_index),
    .cell_dim    (cell_dim),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .re          (re),
    .raddr       (raddr),
    .tag         (tag)
  );

  ccbv_store #(
    .SIDE       (SIDE),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ccbv_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_acc (
    .clk         (clk),
    .rst         (rst),
    .threshold   (cfg.threshold),
    .tag         (tag),
    .rdata       (rdata),
    .done        (done),
    .birth_value (birth_value)
  );

endmodule

// ----- rtl/ccbv_checker.sv -----
// Port-level timing checks for the cubical cell birth value block, bound to its top level.
// Depends on ccbv_pkg for the operation and dimension codes.
module ccbv_checker
  import ccbv_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             operation,
  input logic [DIM_W-1:0] cell_dim,
  input logic             done
);

  // A write request never makes the block busy and never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_WRITE)) |=> (!busy && !done))
    else $error("write request caused busy or a result");

  // A query request makes the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_QUERY)) |=> busy)
    else $error("query request did not raise busy");

  // A vertex query has a single corner and always produces a result.
  a_vertex_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_QUERY) && (cell_dim == DIM_VERTEX)) |-> ##3 done)
    else $error("vertex query result missing");

  // Results are never back to back and appear only when the block is free.
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy ##1 !done))
    else $error("result strobe spacing violated");

endmodule

bind cubical_cell_birth_value_core ccbv_checker u_ccbv_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .cell_dim  (cell_dim),
  .done      (done)
);
